>>> hw/rtl/i2c_display_command_writer_unit_defines.svh
// Assertion macros for the I2C display command writer.
// Included by the port checker; depends on nothing else.
`ifndef I2C_DISPLAY_COMMAND_WRITER_UNIT_DEFINES_SVH
`define I2C_DISPLAY_COMMAND_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define I2CDW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define I2CDW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/i2cdw_pkg.sv
// Shared types and constants for the I2C display command writer.
// Used by the sequencer, the output register and the top level.
package i2cdw_pkg;

    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR    = 2'd1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd24;
    localparam logic [7:0] DEV_ADDR_RST    = 8'h78;
    localparam logic [7:0] CTRL_CMD        = 8'h00;
    localparam logic [7:0] CTRL_DATA       = 8'h40;
    localparam logic [4:0] PAGE_CMD_HI     = 5'b10110;  // 0xB0 >> 3
    localparam logic [3:0] COL_HI_CMD_HI   = 4'h1;      // 0x10 >> 4

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_CMD_BYTE = 2'd1,
        OP_DATA     = 2'd2,
        OP_SET_ADDR = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_START_C  = 4'd3,
        PH_BIT_SET  = 4'd4,
        PH_BIT_HIGH = 4'd5,
        PH_BIT_LOW  = 4'd6,
        PH_ACK_HIGH = 4'd7,
        PH_ACK_LOW  = 4'd8,
        PH_STOP_A   = 4'd9,
        PH_STOP_B   = 4'd10
    } t_phase;

    typedef struct packed {
        logic       sda_in;
        logic [6:0] column;
        logic [2:0] page;
        logic [7:0] byte_value;
        t_op        operation;
    } t_item;

    typedef struct packed {
        logic nack_seen;
        logic done_res;
        logic busy_res;
        logic sda_level;
        logic scl_level;
    } t_result;

endpackage

>>> hw/rtl/i2cdw_seq.sv
// Bus sequencer of the I2C display command writer: configuration registers,
// phase state and line drive. Depends on i2cdw_pkg.
module i2cdw_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [i2cdw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_step,
    input  i2cdw_pkg::t_item                  i_item,
    output i2cdw_pkg::t_result                o_result
);
    import i2cdw_pkg::*;

    logic [7:0] r_half, r_dev_addr;
    t_phase     r_phase, n_phase;
    logic [7:0] r_delay, n_delay;
    logic [2:0] r_bit, n_bit;
    logic [1:0] r_byte_slot, n_byte_slot;
    logic [7:0] r_shift, n_shift;
    logic [1:0] r_cmd_slot, n_cmd_slot;
    logic [2:0] r_page, n_page;
    logic [6:0] r_column, n_column;
    logic [7:0] r_payload, n_payload;
    logic       r_is_data, n_is_data;
    logic       r_nack, n_nack;
    logic       r_scl, n_scl;
    logic       r_sda, n_sda;

    logic [7:0] hold_ticks;
    logic [7:0] delay_dec;
    logic [7:0] payload_byte;
    logic       enter;
    logic       done;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half     <= HALF_PERIOD_RST;
            r_dev_addr <= DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_half     <= i_cfg_data;
                CFG_DEV_ADDR:    r_dev_addr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Zero half period counts as one tick
    assign hold_ticks = (r_half == 8'd0) ? 8'd1 : r_half;
    assign delay_dec  = r_delay - 8'd1;

    // Payload of the current transaction
    always_comb begin
        if (!r_is_data && r_cmd_slot == 2'd0) begin
            payload_byte = {PAGE_CMD_HI, r_page};
        end else if (!r_is_data && r_cmd_slot == 2'd1) begin
            payload_byte = {COL_HI_CMD_HI, 1'b0, r_column[6:4]};
        end else begin
            payload_byte = r_payload;
        end
    end

    // Next phase and line levels for one tick
    always_comb begin
        n_phase     = r_phase;
        n_delay     = r_delay;
        n_bit       = r_bit;
        n_byte_slot = r_byte_slot;
        n_shift     = r_shift;
        n_cmd_slot  = r_cmd_slot;
        n_page      = r_page;
        n_column    = r_column;
        n_payload   = r_payload;
        n_is_data   = r_is_data;
        n_nack      = r_nack;
        n_scl       = r_scl;
        n_sda       = r_sda;
        enter       = 1'b0;
        done        = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                if (i_item.operation != OP_TICK) begin
                    n_nack   = 1'b0;
                    n_page   = i_item.page;
                    n_column = i_item.column;
                    if (i_item.operation == OP_SET_ADDR) begin
                        n_is_data  = 1'b0;
                        n_cmd_slot = 2'd0;
                        n_payload  = {4'h0, i_item.column[3:0]};
                    end else begin
                        n_is_data  = (i_item.operation == OP_DATA);
                        n_cmd_slot = 2'd2;
                        n_payload  = i_item.byte_value;
                    end
                    n_phase = PH_START_A;
                    enter   = 1'b1;
                end
            end
            PH_START_A, PH_START_B, PH_START_C, PH_BIT_SET, PH_BIT_HIGH, PH_BIT_LOW,
            PH_ACK_HIGH, PH_ACK_LOW, PH_STOP_A, PH_STOP_B: begin
                n_delay = delay_dec;
                if (delay_dec == 8'd0) begin
                    enter = 1'b1;
                    case (r_phase)
                        PH_START_A:  n_phase = PH_START_B;
                        PH_START_B:  n_phase = PH_START_C;
                        PH_START_C: begin
                            n_byte_slot = 2'd0;
                            n_bit       = 3'd0;
                            n_shift     = r_dev_addr;
                            n_phase     = PH_BIT_SET;
                        end
                        PH_BIT_SET:  n_phase = PH_BIT_HIGH;
                        PH_BIT_HIGH: n_phase = PH_BIT_LOW;
                        PH_BIT_LOW: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 3'd1;
                            n_phase = (n_bit == 3'd0) ? PH_ACK_HIGH : PH_BIT_SET;
                        end
                        PH_ACK_HIGH: begin
                            if (i_item.sda_in) begin
                                n_nack = 1'b1;
                            end
                            n_phase = PH_ACK_LOW;
                        end
                        PH_ACK_LOW: begin
                            if (r_byte_slot < 2'd2) begin
                                n_byte_slot = r_byte_slot + 2'd1;
                                n_shift     = (n_byte_slot == 2'd1)
                                            ? (r_is_data ? CTRL_DATA : CTRL_CMD)
                                            : payload_byte;
                                n_bit       = 3'd0;
                                n_phase     = PH_BIT_SET;
                            end else begin
                                n_phase = PH_STOP_A;
                            end
                        end
                        PH_STOP_A:   n_phase = PH_STOP_B;
                        default: begin
                            // End of stop: next command of the set or finish
                            if (r_cmd_slot < 2'd2) begin
                                n_cmd_slot = r_cmd_slot + 2'd1;
                                n_phase    = PH_START_A;
                            end else begin
                                enter   = 1'b0;
                                done    = 1'b1;
                                n_phase = PH_IDLE;
                                n_delay = 8'd0;
                                n_scl   = 1'b1;
                                n_sda   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                // Unreachable code: release the lines and drop to idle
                n_phase = PH_IDLE;
                n_delay = 8'd0;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        endcase

        // Phase entry: reload the delay and set the lines
        if (enter) begin
            n_delay = hold_ticks;
            case (n_phase)
                PH_START_A:  begin n_scl = 1'b1; n_sda = 1'b1; end
                PH_START_B:  n_sda = 1'b0;
                PH_START_C:  n_scl = 1'b0;
                PH_BIT_SET:  n_sda = n_shift[7];
                PH_BIT_HIGH: n_scl = 1'b1;
                PH_BIT_LOW:  n_scl = 1'b0;
                PH_ACK_HIGH: begin n_sda = 1'b1; n_scl = 1'b1; end
                PH_ACK_LOW:  n_scl = 1'b0;
                PH_STOP_A:   begin n_sda = 1'b0; n_scl = 1'b1; end
                PH_STOP_B:   n_sda = 1'b1;
                default: ;
            endcase
        end
    end

    // Result of this tick
    assign o_result.scl_level = n_scl;
    assign o_result.sda_level = n_sda;
    assign o_result.busy_res  = (n_phase != PH_IDLE);
    assign o_result.done_res  = done;
    assign o_result.nack_seen = done & n_nack;

    // Advance state on each transferred tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_delay     <= 8'd0;
            r_bit       <= 3'd0;
            r_byte_slot <= 2'd0;
            r_shift     <= 8'd0;
            r_cmd_slot  <= 2'd0;
            r_page      <= 3'd0;
            r_column    <= 7'd0;
            r_payload   <= 8'd0;
            r_is_data   <= 1'b0;
            r_nack      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_delay     <= n_delay;
            r_bit       <= n_bit;
            r_byte_slot <= n_byte_slot;
            r_shift     <= n_shift;
            r_cmd_slot  <= n_cmd_slot;
            r_page      <= n_page;
            r_column    <= n_column;
            r_payload   <= n_payload;
            r_is_data   <= n_is_data;
            r_nack      <= n_nack;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
        end
    end

endmodule

>>> hw/rtl/i2cdw_out_reg.sv
// Output register of the I2C display command writer: holds one result
// until the downstream side takes it. Depends on i2cdw_pkg.
module i2cdw_out_reg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  i2cdw_pkg::t_result                  i_result,
    output logic                                o_can_load,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [i2cdw_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import i2cdw_pkg::*;

    logic    r_valid;
    t_result r_data;

    // Accept a new result when empty or when the held one leaves now
    assign o_can_load = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {(M_TDATA_W - $bits(t_result))'(0), r_data};

endmodule

>>> hw/rtl/i2c_display_command_writer_unit.sv
// I2C display command writer. Every transferred input item is one bus tick:
// the block advances its start/address/control/payload/stop sequence by that
// tick and returns one result with the SCL and SDA drive levels and the busy,
// done and NACK status. A tick is taken every clock cycle as long as the single
// output register is empty or its result is taken, so the input keeps flowing;
// a tick's result appears on the output in the cycle after the transfer. Each
// line phase lasts half_period_ticks ticks (zero counts as one), so one byte
// with its ack spans 26 phases. Configuration writes are taken at any cycle.
module i2c_display_command_writer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input ticks
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [7:0] byte_value, [10:8] page, [17:11] column, [18] sda_in, rest zero
    input  logic [i2cdw_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  logic [1:0]                          i_s_tuser,
    // Results
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] nack_seen
    output logic [i2cdw_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // Configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2cdw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);
    import i2cdw_pkg::*;

    t_item   item;
    t_result result;
    logic    can_load;
    logic    step;

    // Unpack the input transfer
    assign item.operation  = t_op'(i_s_tuser);
    assign item.byte_value = i_s_tdata[7:0];
    assign item.page       = i_s_tdata[10:8];
    assign item.column     = i_s_tdata[17:11];
    assign item.sda_in     = i_s_tdata[18];

    assign o_s_tready  = can_load;
    assign step        = i_s_tvalid && can_load;
    assign o_cfg_ready = 1'b1;

    i2cdw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_item      (item),
        .o_result    (result)
    );

    i2cdw_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (result),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

>>> hw/rtl/i2cdw_checker.sv
// Port checker for the I2C display command writer, bound to the top level.
// Depends on i2c_display_command_writer_unit_defines.svh and i2cdw_pkg.
`include "i2c_display_command_writer_unit_defines.svh"

module i2cdw_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    input logic                                o_m_tvalid,
    input logic [i2cdw_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    // Done finishes the request, so busy is already low
    `I2CDW_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[3], !o_m_tdata[2], "done with busy high")

    // NACK is reported only with done
    `I2CDW_ASSERT_NOW(a_nack_with_done, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[4], o_m_tdata[3], "nack without done")

    // Idle bus has both lines released
    `I2CDW_ASSERT_NOW(a_idle_released, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[2], o_m_tdata[0] && o_m_tdata[1], "idle with a line pulled low")

    // Every input transfer produces a result in the next cycle
    `I2CDW_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_s_tvalid && o_s_tready, o_m_tvalid, "no result after transfer")

    // An empty output register never stalls the input
    `I2CDW_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "input stalled with empty output")

endmodule

bind i2c_display_command_writer_unit i2cdw_checker u_i2cdw_checker (.*);

>>> test/i2c_display_command_writer_unit_tb.sv
// Self-checking bench for the I2C display command writer: streams bus ticks,
// predicts SCL/SDA levels and busy/done/NACK status per tick, compares results.
// Depends on i2cdw_pkg and i2c_display_command_writer_unit.
module i2c_display_command_writer_unit_tb;
    import i2cdw_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int TAIL_CYCLES = 4;

    // Indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [1:0]           s_tuser   = OP_TICK;
    logic                 o_m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HALF_PERIOD;
    logic [7:0]           cfg_data  = '0;

    i2c_display_command_writer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bench state: ticks waiting to go out, line levels waiting to come back
    t_item   tick_q[$];
    t_result pending_levels[$];
    int      fails     = 0;
    int      cycles    = 0;
    int      tx_gap    = 0;
    int      rx_gap    = 0;
    bit      tx_steady = 1'b0;
    bit      rx_steady = 1'b0;
    int      nack_odds = 0;   // 0: always ack, 1: never ack, n: NACK one tick in n
    string   field_name[5] = '{"scl_level", "sda_level", "busy_res", "done_res", "nack_seen"};

    // Shadow of the bus sequencer and its registers
    logic [7:0] cfg_half    = HALF_PERIOD_RST;
    logic [7:0] cfg_addr    = DEV_ADDR_RST;
    t_phase     bus_phase   = PH_IDLE;
    logic [7:0] hold_left   = '0;
    logic [2:0] bit_idx     = '0;
    logic [1:0] byte_idx    = '0;
    logic [7:0] shift_byte  = '0;
    logic [1:0] cmd_slot    = '0;
    logic [2:0] want_page   = '0;
    logic [6:0] want_col    = '0;
    logic [7:0] payload     = '0;
    logic       data_write  = 1'b0;
    logic       nack_any    = 1'b0;
    logic       scl_drv     = 1'b1;
    logic       sda_drv     = 1'b1;

    // Set the lines for a phase and load its hold time
    function automatic void enter_phase(t_phase p);
        bus_phase = p;
        hold_left = (cfg_half == 8'd0) ? 8'd1 : cfg_half;
        case (p)
            PH_START_A: begin
                scl_drv = 1'b1;
                sda_drv = 1'b1;
            end
            PH_START_B:  sda_drv = 1'b0;
            PH_START_C:  scl_drv = 1'b0;
            PH_BIT_SET:  sda_drv = shift_byte[7];
            PH_BIT_HIGH: scl_drv = 1'b1;
            PH_BIT_LOW:  scl_drv = 1'b0;
            PH_ACK_HIGH: begin
                sda_drv = 1'b1;
                scl_drv = 1'b1;
            end
            PH_ACK_LOW:  scl_drv = 1'b0;
            PH_STOP_A: begin
                sda_drv = 1'b0;
                scl_drv = 1'b1;
            end
            PH_STOP_B:   sda_drv = 1'b1;
            default: ;
        endcase
    endfunction

    // Advance the sequencer by one tick and return the line levels it drives
    function automatic t_result advance_bus(t_item it);
        t_result r;
        logic    finished;
        finished = 1'b0;
        if (bus_phase == PH_IDLE) begin
            if (it.operation != OP_TICK) begin
                nack_any  = 1'b0;
                want_page = it.page;
                want_col  = it.column;
                if (it.operation == OP_SET_ADDR) begin
                    data_write = 1'b0;
                    cmd_slot   = 2'd0;
                    payload    = {4'h0, it.column[3:0]};
                end else begin
                    data_write = (it.operation == OP_DATA);
                    cmd_slot   = 2'd2;
                    payload    = it.byte_value;
                end
                enter_phase(PH_START_A);
            end
        end else begin
            hold_left = hold_left - 8'd1;
            if (hold_left == 8'd0) begin
                case (bus_phase)
                    PH_START_A: enter_phase(PH_START_B);
                    PH_START_B: enter_phase(PH_START_C);
                    PH_START_C: begin
                        byte_idx   = 2'd0;
                        bit_idx    = 3'd0;
                        shift_byte = cfg_addr;
                        enter_phase(PH_BIT_SET);
                    end
                    PH_BIT_SET:  enter_phase(PH_BIT_HIGH);
                    PH_BIT_HIGH: enter_phase(PH_BIT_LOW);
                    PH_BIT_LOW: begin
                        shift_byte = {shift_byte[6:0], 1'b0};
                        bit_idx    = bit_idx + 3'd1;
                        enter_phase(bit_idx == 3'd0 ? PH_ACK_HIGH : PH_BIT_SET);
                    end
                    PH_ACK_HIGH: begin
                        if (it.sda_in)
                            nack_any = 1'b1;
                        enter_phase(PH_ACK_LOW);
                    end
                    PH_ACK_LOW: begin
                        if (byte_idx < 2'd2) begin
                            byte_idx = byte_idx + 2'd1;
                            // control byte first, then the payload of this command slot
                            if (byte_idx == 2'd1)
                                shift_byte = data_write ? CTRL_DATA : CTRL_CMD;
                            else if (!data_write && cmd_slot == 2'd0)
                                shift_byte = {PAGE_CMD_HI, want_page};
                            else if (!data_write && cmd_slot == 2'd1)
                                shift_byte = {COL_HI_CMD_HI, 1'b0, want_col[6:4]};
                            else
                                shift_byte = payload;
                            bit_idx = 3'd0;
                            enter_phase(PH_BIT_SET);
                        end else begin
                            enter_phase(PH_STOP_A);
                        end
                    end
                    PH_STOP_A: enter_phase(PH_STOP_B);
                    PH_STOP_B: begin
                        if (cmd_slot < 2'd2) begin
                            cmd_slot = cmd_slot + 2'd1;
                            enter_phase(PH_START_A);
                        end else begin
                            bus_phase = PH_IDLE;
                            hold_left = 8'd0;
                            scl_drv   = 1'b1;
                            sda_drv   = 1'b1;
                            finished  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        r.scl_level = scl_drv;
        r.sda_level = sda_drv;
        r.busy_res  = (bus_phase != PH_IDLE);
        r.done_res  = finished;
        r.nack_seen = finished & nack_any;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic t_item make_tick(t_op op, logic [7:0] bv, logic [2:0] pg, logic [6:0] col);
        t_item it;
        it.operation  = op;
        it.byte_value = bv;
        it.page       = pg;
        it.column     = col;
        if (nack_odds == 0)
            it.sda_in = 1'b0;
        else if (nack_odds == 1)
            it.sda_in = 1'b1;
        else
            it.sda_in = ($urandom_range(1, nack_odds) == 1);
        return it;
    endfunction

    // Push a run of plain ticks
    task automatic push_ticks(input int count);
        repeat (count)
            tick_q.push_back(make_tick(OP_TICK, 8'($urandom), 3'($urandom), 7'($urandom)));
    endtask

    // Wait until every tick went out and every result came back;
    // look between edges so the driver and the monitor have both run
    task automatic settle();
        do @(negedge i_clk);
        while (tick_q.size() != 0 || s_tvalid || pending_levels.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Feed plain ticks until the sequencer is back to idle, at a short half period
    task automatic drain_request();
        settle();
        if (bus_phase != PH_IDLE && cfg_half > 8'd1)
            write_reg(CFG_HALF_PERIOD, 8'd1);
        while (bus_phase != PH_IDLE) begin
            push_ticks(16);
            settle();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
            cfg_half = val;
        else if (idx == CFG_DEV_ADDR)
            cfg_addr = val;
    endtask

    // Random mix: about half plain ticks, the rest requests (ignored while busy)
    task automatic run_setting(input logic [7:0] half, input logic [7:0] addr,
                               input int odds, input int count);
        t_op op;
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_DEV_ADDR, addr);
        nack_odds = odds;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            op = ($urandom_range(0, 7) < 4) ? OP_TICK : t_op'($urandom_range(1, 3));
            tick_q.push_back(make_tick(op, 8'($urandom), 3'($urandom), 7'($urandom)));
        end
        drain_request();
    endtask

    // Drive ticks: advance on transfer or empty bus, insert random gaps
    always @(posedge i_clk) begin : drive_ticks
        t_item cur;
        t_item nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                cur.operation  = t_op'(s_tuser);
                cur.byte_value = s_tdata[7:0];
                cur.page       = s_tdata[10:8];
                cur.column     = s_tdata[17:11];
                cur.sda_in     = s_tdata[18];
                pending_levels.push_back(advance_bus(cur));
            end
            if (!s_tvalid || o_s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    nxt = tick_q.pop_front();
                    s_tdata  <= {5'd0, nxt.sda_in, nxt.column, nxt.page, nxt.byte_value};
                    s_tuser  <= nxt.operation;
                    s_tvalid <= 1'b1;
                    tx_gap = tx_steady ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take results, stall at random, compare each field with the oldest expectation
    always @(posedge i_clk) begin : check_levels
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (pending_levels.size() == 0) begin
                    $error("result %h with no tick waiting", o_m_tdata);
                    fails++;
                end else begin
                    want = pending_levels.pop_front();
                    for (int i = 0; i < 5; i++) begin
                        if (o_m_tdata[i] !== want[i]) begin
                            $error("%s: expected %0b, got %0b", field_name[i], want[i],
                                   o_m_tdata[i]);
                            fails++;
                        end
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = rx_steady ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset values: default half period and device address on the first bits
        nack_odds = 0;
        tick_q.push_back(make_tick(OP_DATA, 8'hC3, 3'd0, 7'd0));
        push_ticks(150);
        drain_request();

        // Zero half period runs as one tick; all-zero device address
        write_reg(CFG_HALF_PERIOD, 8'd0);
        write_reg(CFG_DEV_ADDR, 8'h00);
        nack_odds = 1;
        tick_q.push_back(make_tick(OP_TICK, 8'hFF, 3'd7, 7'h7F));
        nack_odds = 0;
        tick_q.push_back(make_tick(OP_CMD_BYTE, 8'h00, 3'd0, 7'd0));
        tick_q.push_back(make_tick(OP_DATA, 8'hFF, 3'd7, 7'h7F));
        drain_request();

        // Every ack read high
        nack_odds = 1;
        tick_q.push_back(make_tick(OP_DATA, 8'hFF, 3'd7, 7'h7F));
        drain_request();

        // Set-address extremes, with a command request dropped while busy
        nack_odds = 0;
        tick_q.push_back(make_tick(OP_SET_ADDR, 8'h00, 3'd7, 7'h7F));
        drain_request();
        tick_q.push_back(make_tick(OP_SET_ADDR, 8'hFF, 3'd0, 7'h00));
        tick_q.push_back(make_tick(OP_CMD_BYTE, 8'hA5, 3'd5, 7'h2A));
        drain_request();

        // Writes past the register list must leave both registers alone
        write_reg(CFG_SPARE_A, 8'h01);
        write_reg(CFG_SPARE_B, 8'hFF);
        tick_q.push_back(make_tick(OP_CMD_BYTE, 8'h5A, 3'd2, 7'h15));
        drain_request();

        // Random traffic across several settings
        run_setting(8'd1, 8'hFF, 16, 150);
        run_setting(8'd2, 8'($urandom), 2, 150);
        run_setting(8'd3, 8'($urandom), 0, 100);
        run_setting(8'd1, 8'($urandom), 16, 150);
        run_setting(8'd5, DEV_ADDR_RST, 8, 100);

        // Longest half period: hold the first phases, then finish at a short one
        write_reg(CFG_HALF_PERIOD, 8'd255);
        write_reg(CFG_DEV_ADDR, 8'($urandom));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        nack_odds = 4;
        tick_q.push_back(make_tick(OP_CMD_BYTE, 8'($urandom), 3'($urandom), 7'($urandom)));
        push_ticks(280);
        drain_request();

        settle();
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
